// ===== hdl/healpix_ring_pixel_to_angle_top_macros.svh =====
// ----------------------------------------------------------------------------
// healpix ring pixel to angle assertion macros
// shared property shorthands, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef HEALPIX_RING_PIXEL_TO_ANGLE_TOP_MACROS_SVH
`define HEALPIX_RING_PIXEL_TO_ANGLE_TOP_MACROS_SVH

// same-cycle implication
`define HRPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HRPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hrpa_pkg.sv =====
// ----------------------------------------------------------------------------
// hrpa_pkg
// widths, region codes and stage records of the ring pixel to angle pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hrpa_pkg;

  localparam int PIX_W      = 44;
  localparam int N_W        = 21;
  localparam int REGION_W   = 2;
  localparam int RING_W     = 22;
  localparam int IPHI_W     = 23;
  localparam int Z_W        = 32;
  localparam int PHI_W      = 33;
  localparam int RAD_W      = 44;
  localparam int RREM_W     = 23;
  localparam int ROOT_W     = 22;
  localparam int DVD_W      = 42;
  localparam int DSH_W      = 22;
  localparam int ROOT_STEPS = 22;
  localparam int K_W        = 21;
  localparam int KSQ_W      = 41;
  localparam int M_W        = 23;
  localparam int ZN_W       = 42;
  localparam int FRAC_STEPS = 33;
  localparam int Q_W        = 33;
  localparam int T_W        = 55;
  localparam int PL_W       = 55;
  localparam int PH_W       = 53;

  localparam logic [N_W-1:0] N_MAX = N_W'(1) << 20;
  localparam logic [31:0]    PI_LO = 32'h885A308D;
  localparam logic [29:0]    PI_HI = 30'h3243F6A8;

  localparam logic [REGION_W-1:0] REG_NORTH = 2'd0;
  localparam logic [REGION_W-1:0] REG_BELT  = 2'd1;
  localparam logic [REGION_W-1:0] REG_SOUTH = 2'd2;

  typedef struct packed {
    logic [N_W-1:0]   n;
    logic [N_W+1:0]   n3;
    logic [N_W+1:0]   n4;
    logic [ZN_W-1:0]  nsq3;
    logic [PIX_W-1:0] npix;
    logic [ZN_W-1:0]  ncap;
    logic [PIX_W-1:0] nbelt;
  } cfg_t;

  typedef struct packed {
    logic [REGION_W-1:0] region;
    logic                invalid;
    logic [RAD_W-1:0]    rad;
    logic [PIX_W-1:0]    pv;
    logic [DVD_W-1:0]    dvd;
    logic [1:0]          ip_lo;
  } front_t;

  typedef struct packed {
    logic [REGION_W-1:0] region;
    logic                invalid;
    logic [RAD_W-1:0]    rad;
    logic [RREM_W-1:0]   rem;
    logic [ROOT_W-1:0]   root;
    logic [PIX_W-1:0]    pv;
    logic [DSH_W-1:0]    dsh;
    logic [N_W-1:0]      r;
    logic [ROOT_W-1:0]   q;
    logic [1:0]          ip_lo;
  } rstage_t;

  typedef struct packed {
    logic [REGION_W-1:0] region;
    logic                invalid;
    logic [RING_W-1:0]   ring;
    logic [IPHI_W-1:0]   iphi;
    logic                zneg;
    logic [ZN_W-1:0]     zrem;
    logic [Q_W-1:0]      zbits;
    logic [ZN_W-1:0]     zden;
    logic [Q_W-1:0]      zq;
    logic [N_W-1:0]      prem;
    logic [Q_W-1:0]      pbits;
    logic [N_W-1:0]      pden;
    logic [Q_W-1:0]      pq;
  } dstage_t;

endpackage

`default_nettype wire

// ===== hdl/hrpa_if.sv =====
// ----------------------------------------------------------------------------
// hrpa channel interfaces
// valid/ready channels for pixel indices and angle results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hrpa_in_if;
  import hrpa_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_index;
  modport source (output valid, output pixel_index, input ready);
  modport sink (input valid, input pixel_index, output ready);
endinterface

interface hrpa_out_if;
  import hrpa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REGION_W-1:0]   region;
  logic [RING_W-1:0]     ring_number;
  logic [IPHI_W-1:0]     ring_pixel;
  logic signed [Z_W-1:0] z_cos_theta;
  logic [PHI_W-1:0]      phi_angle;
  logic                  invalid;
  modport source (output valid, output region, output ring_number, output ring_pixel,
                  output z_cos_theta, output phi_angle, output invalid, input ready);
  modport sink (input valid, input region, input ring_number, input ring_pixel,
                input z_cos_theta, input phi_angle, input invalid, output ready);
endinterface

`default_nettype wire

// ===== hdl/hrpa_front.sv =====
// ----------------------------------------------------------------------------
// hrpa_front
// input register and region classification, root and divide operands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrpa_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_v,
  input  wire logic [hrpa_pkg::PIX_W-1:0] in_pix,
  input  wire hrpa_pkg::cfg_t            cfg,
  output logic                           out_v,
  output hrpa_pkg::front_t               out_d
);
  import hrpa_pkg::*;

  logic             s0_v_r;
  logic [PIX_W-1:0] s0_pix_r;
  logic             s1_v_r;
  front_t           s1_r;
  front_t           s1_nxt;
  logic [PIX_W-1:0] ip_s;
  logic [PIX_W-1:0] ip_sm1;
  logic [PIX_W-1:0] ip_b;
  logic             is_north;
  logic             is_belt;

  always_comb begin
    is_north = s0_pix_r < {2'b00, cfg.ncap};
    is_belt  = s0_pix_r < cfg.nbelt;
    ip_s     = cfg.npix - s0_pix_r;
    ip_sm1   = ip_s - PIX_W'(1);
    ip_b     = s0_pix_r - {2'b00, cfg.ncap};
    s1_nxt.invalid = s0_pix_r >= cfg.npix;
    if (is_north) begin
      s1_nxt.region = REG_NORTH;
    end else if (is_belt) begin
      s1_nxt.region = REG_BELT;
    end else begin
      s1_nxt.region = REG_SOUTH;
    end
    s1_nxt.rad   = is_north ? {s0_pix_r[PIX_W-2:0], 1'b1} : {ip_sm1[PIX_W-2:0], 1'b1};
    s1_nxt.pv    = is_north ? s0_pix_r : ip_s;
    s1_nxt.dvd   = ip_b[PIX_W-1:2];
    s1_nxt.ip_lo = ip_b[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_v;
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_pix_r <= in_pix;
      s1_r     <= s1_nxt;
    end
  end

  assign out_v = s1_v_r;
  assign out_d = s1_r;

endmodule

`default_nettype wire

// ===== hdl/hrpa_root_div.sv =====
// ----------------------------------------------------------------------------
// hrpa_root_div
// pipelined integer square root for the caps and divide by nside for the belt
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrpa_root_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_v,
  input  wire hrpa_pkg::front_t  in_d,
  input  wire hrpa_pkg::cfg_t    cfg,
  output logic                   out_v,
  output hrpa_pkg::rstage_t      out_d
);
  import hrpa_pkg::*;

  rstage_t                 st_in [ROOT_STEPS];
  rstage_t                 st_r  [ROOT_STEPS];
  logic [ROOT_STEPS-1:0]   v_r;

  function automatic rstage_t root_step(input rstage_t s, input logic [N_W-1:0] n);
    rstage_t           o;
    logic [RREM_W+1:0] rem2;
    logic [RREM_W+1:0] trial;
    logic [N_W:0]      r2;
    logic              sq_ge;
    logic              dv_ge;
    o      = s;
    rem2   = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial  = {1'b0, s.root, 2'b01};
    sq_ge  = rem2 >= trial;
    o.rem  = sq_ge ? RREM_W'(rem2 - trial) : rem2[RREM_W-1:0];
    o.root = {s.root[ROOT_W-2:0], sq_ge};
    o.rad  = s.rad << 2;
    r2     = {s.r, s.dsh[DSH_W-1]};
    dv_ge  = r2 >= {1'b0, n};
    o.r    = dv_ge ? N_W'(r2 - {1'b0, n}) : r2[N_W-1:0];
    o.q    = {s.q[ROOT_W-2:0], dv_ge};
    o.dsh  = s.dsh << 1;
    return o;
  endfunction

  always_comb begin
    st_in[0].region  = in_d.region;
    st_in[0].invalid = in_d.invalid;
    st_in[0].rad     = in_d.rad;
    st_in[0].rem     = '0;
    st_in[0].root    = '0;
    st_in[0].pv      = in_d.pv;
    st_in[0].dsh     = in_d.dvd[DSH_W-1:0];
    st_in[0].r       = {1'b0, in_d.dvd[DVD_W-1:DSH_W]};
    st_in[0].q       = '0;
    st_in[0].ip_lo   = in_d.ip_lo;
    for (int i = 1; i < ROOT_STEPS; i++) begin
      st_in[i] = st_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[ROOT_STEPS-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < ROOT_STEPS; i++) begin
        st_r[i] <= root_step(st_in[i], cfg.n);
      end
    end
  end

  assign out_v = v_r[ROOT_STEPS-1];
  assign out_d = st_r[ROOT_STEPS-1];

endmodule

`default_nettype wire

// ===== hdl/hrpa_ring_map.sv =====
// ----------------------------------------------------------------------------
// hrpa_ring_map
// ring, pixel in ring, z ratio operands and phi product over four stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrpa_ring_map (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_v,
  input  wire hrpa_pkg::rstage_t in_d,
  input  wire hrpa_pkg::cfg_t    cfg,
  output logic                   out_v,
  output hrpa_pkg::dstage_t      out_d
);
  import hrpa_pkg::*;

  typedef struct packed {
    logic [REGION_W-1:0] region;
    logic                invalid;
    logic [K_W-1:0]      k;
    logic [KSQ_W-1:0]    ksq;
    logic [PIX_W-1:0]    pv;
    logic [ROOT_W-1:0]   q;
    logic [N_W-1:0]      r;
    logic [1:0]          ip_lo;
  } b1_t;

  typedef struct packed {
    logic [REGION_W-1:0] region;
    logic                invalid;
    logic [RING_W-1:0]   ring;
    logic [IPHI_W-1:0]   iphi;
    logic                zneg;
    logic [M_W-1:0]      m;
    logic [N_W-1:0]      d;
    logic [ZN_W-1:0]     znum;
    logic [ZN_W-1:0]     zden;
  } b2_t;

  typedef struct packed {
    b2_t             b2;
    logic [PL_W-1:0] pl;
    logic [PH_W-1:0] ph;
  } c1_t;

  logic [3:0]      v_r;
  b1_t             b1_r;
  b1_t             b1_nxt;
  b2_t             b2_r;
  b2_t             b2_nxt;
  c1_t             c1_r;
  c1_t             c1_nxt;
  dstage_t         c2_r;
  dstage_t         c2_nxt;
  logic [K_W+1:0]  kinc;
  logic [PIX_W:0]  iphi_w;
  logic [IPHI_W-1:0] iphi_m1;
  logic [IPHI_W-1:0] rem4n;
  logic [RING_W-1:0] diff;
  logic            q_gt;
  logic [PL_W:0]   sum_lo;
  logic [T_W-1:0]  tval;

  always_comb begin
    kinc          = (K_W+2)'(in_d.root) + (K_W+2)'(1);
    b1_nxt.region = in_d.region;
    b1_nxt.invalid = in_d.invalid;
    b1_nxt.k      = kinc[K_W:1];
    b1_nxt.ksq    = KSQ_W'(kinc[K_W:1] * kinc[K_W:1]);
    b1_nxt.pv     = in_d.pv;
    b1_nxt.q      = in_d.q;
    b1_nxt.r      = in_d.r;
    b1_nxt.ip_lo  = in_d.ip_lo;
  end

  always_comb begin
    rem4n   = {b1_r.r, b1_r.ip_lo};
    q_gt    = b1_r.q > {1'b0, cfg.n};
    diff    = q_gt ? b1_r.q - {1'b0, cfg.n} : {1'b0, cfg.n} - b1_r.q;
    iphi_w  = '0;
    iphi_m1 = '0;
    b2_nxt.region  = b1_r.region;
    b2_nxt.invalid = b1_r.invalid;
    case (b1_r.region)
      REG_NORTH: begin
        iphi_w  = {1'b0, b1_r.pv} + (PIX_W+1)'(1) - (PIX_W+1)'({b1_r.ksq, 1'b0})
                  + (PIX_W+1)'({b1_r.k, 1'b0});
        iphi_m1 = iphi_w[IPHI_W-1:0] - IPHI_W'(1);
        b2_nxt.ring = RING_W'(b1_r.k);
        b2_nxt.iphi = iphi_w[IPHI_W-1:0];
        b2_nxt.zneg = 1'b0;
        b2_nxt.m    = {iphi_m1[M_W-2:0], 1'b1};
        b2_nxt.d    = b1_r.k;
        b2_nxt.znum = cfg.nsq3 - ZN_W'(b1_r.ksq);
        b2_nxt.zden = cfg.nsq3;
      end
      REG_BELT: begin
        b2_nxt.ring = b1_r.q + RING_W'(cfg.n);
        b2_nxt.iphi = rem4n + IPHI_W'(1);
        b2_nxt.zneg = q_gt;
        b2_nxt.m    = {rem4n[M_W-2:0], ~b1_r.q[0]};
        b2_nxt.d    = cfg.n;
        b2_nxt.znum = ZN_W'({diff, 1'b0});
        b2_nxt.zden = ZN_W'(cfg.n3);
      end
      default: begin
        iphi_w  = (PIX_W+1)'({b1_r.ksq, 1'b0}) + (PIX_W+1)'({b1_r.k, 1'b0})
                  + (PIX_W+1)'(1) - {1'b0, b1_r.pv};
        iphi_m1 = iphi_w[IPHI_W-1:0] - IPHI_W'(1);
        b2_nxt.ring = RING_W'(cfg.n4 - (N_W+2)'(b1_r.k));
        b2_nxt.iphi = iphi_w[IPHI_W-1:0];
        b2_nxt.zneg = 1'b1;
        b2_nxt.m    = {iphi_m1[M_W-2:0], 1'b1};
        b2_nxt.d    = b1_r.k;
        b2_nxt.znum = cfg.nsq3 - ZN_W'(b1_r.ksq);
        b2_nxt.zden = cfg.nsq3;
      end
    endcase
  end

  always_comb begin
    c1_nxt.b2 = b2_r;
    c1_nxt.pl = PL_W'(PI_LO) * PL_W'(b2_r.m);
    c1_nxt.ph = PH_W'(PI_HI) * PH_W'(b2_r.m);
  end

  always_comb begin
    sum_lo = (PL_W+1)'(c1_r.pl) + (PL_W+1)'({c1_r.b2.d, 31'b0});
    tval   = T_W'(c1_r.ph) + T_W'(sum_lo[PL_W:32]);
    c2_nxt.region  = c1_r.b2.region;
    c2_nxt.invalid = c1_r.b2.invalid;
    c2_nxt.ring    = c1_r.b2.ring;
    c2_nxt.iphi    = c1_r.b2.iphi;
    c2_nxt.zneg    = c1_r.b2.zneg;
    c2_nxt.zrem    = ZN_W'(c1_r.b2.znum[ZN_W-1:2]);
    c2_nxt.zbits   = {c1_r.b2.znum[1:0], (Q_W-2)'(0)};
    c2_nxt.zden    = c1_r.b2.zden;
    c2_nxt.zq      = '0;
    c2_nxt.prem    = tval[Q_W+N_W-1:Q_W];
    c2_nxt.pbits   = tval[Q_W-1:0];
    c2_nxt.pden    = c1_r.b2.d;
    c2_nxt.pq      = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_r <= b1_nxt;
      b2_r <= b2_nxt;
      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
    end
  end

  assign out_v = v_r[3];
  assign out_d = c2_r;

endmodule

`default_nettype wire

// ===== hdl/hrpa_frac_div.sv =====
// ----------------------------------------------------------------------------
// hrpa_frac_div
// two pipelined restoring dividers: z ratio and phi quotient, one bit a stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrpa_frac_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_v,
  input  wire hrpa_pkg::dstage_t in_d,
  output logic                   out_v,
  output hrpa_pkg::dstage_t      out_d
);
  import hrpa_pkg::*;

  dstage_t               st_in [FRAC_STEPS];
  dstage_t               st_r  [FRAC_STEPS];
  logic [FRAC_STEPS-1:0] v_r;

  function automatic dstage_t div_step(input dstage_t s);
    dstage_t       o;
    logic [ZN_W:0] zr2;
    logic [N_W:0]  pr2;
    logic          z_ge;
    logic          p_ge;
    o       = s;
    zr2     = {s.zrem, s.zbits[Q_W-1]};
    z_ge    = zr2 >= {1'b0, s.zden};
    o.zrem  = z_ge ? ZN_W'(zr2 - {1'b0, s.zden}) : zr2[ZN_W-1:0];
    o.zq    = {s.zq[Q_W-2:0], z_ge};
    o.zbits = s.zbits << 1;
    pr2     = {s.prem, s.pbits[Q_W-1]};
    p_ge    = pr2 >= {1'b0, s.pden};
    o.prem  = p_ge ? N_W'(pr2 - {1'b0, s.pden}) : pr2[N_W-1:0];
    o.pq    = {s.pq[Q_W-2:0], p_ge};
    o.pbits = s.pbits << 1;
    return o;
  endfunction

  always_comb begin
    st_in[0] = in_d;
    for (int i = 1; i < FRAC_STEPS; i++) begin
      st_in[i] = st_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[FRAC_STEPS-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < FRAC_STEPS; i++) begin
        st_r[i] <= div_step(st_in[i]);
      end
    end
  end

  assign out_v = v_r[FRAC_STEPS-1];
  assign out_d = st_r[FRAC_STEPS-1];

endmodule

`default_nettype wire

// ===== hdl/healpix_ring_pixel_to_angle_top.sv =====
// ----------------------------------------------------------------------------
// healpix_ring_pixel_to_angle_top: ring pixel index to region, ring, z and phi
// one item per cycle unless the output is blocked with the last stage full,
// through 22 root/divide stages and 33 fraction divide stages in series
// reset clears all valid bits and sets nside to 1
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "healpix_ring_pixel_to_angle_top_macros.svh"

module healpix_ring_pixel_to_angle_top (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  hrpa_in_if.sink                      in_ch,
  hrpa_out_if.source                   out_ch,
  input  wire logic                    cfg_we,
  input  wire logic [hrpa_pkg::N_W-1:0] cfg_wdata
);
  import hrpa_pkg::*;

  logic [N_W-1:0]      n_r;
  logic [KSQ_W-1:0]    nsq_r;
  logic [N_W-1:0]      n_eff;
  logic [2*N_W-1:0]    nsq_full;
  cfg_t                cfg_r;
  cfg_t                cfg_nxt;
  logic                en;
  logic                fr_v;
  front_t              fr_d;
  logic                rd_v;
  rstage_t             rd_d;
  logic                rm_v;
  dstage_t             rm_d;
  logic                last_v;
  dstage_t             last_d;
  logic [Z_W-1:0]      zmag;
  logic                out_v_r;
  logic [REGION_W-1:0] out_region_r;
  logic [RING_W-1:0]   out_ring_r;
  logic [IPHI_W-1:0]   out_iphi_r;
  logic [Z_W-1:0]      out_z_r;
  logic [PHI_W-1:0]    out_phi_r;
  logic                out_inv_r;

  // nside saturation and derived counts
  always_comb begin
    if (cfg_wdata == '0) begin
      n_eff = N_W'(1);
    end else if (cfg_wdata > N_MAX) begin
      n_eff = N_MAX;
    end else begin
      n_eff = cfg_wdata;
    end
    nsq_full      = n_eff * n_eff;
    cfg_nxt.n     = n_r;
    cfg_nxt.n3    = (N_W+2)'({n_r, 1'b0}) + (N_W+2)'(n_r);
    cfg_nxt.n4    = {n_r, 2'b00};
    cfg_nxt.nsq3  = ZN_W'({nsq_r, 1'b0}) + ZN_W'(nsq_r);
    cfg_nxt.npix  = {cfg_nxt.nsq3, 2'b00};
    cfg_nxt.ncap  = ZN_W'({nsq_r, 1'b0}) - ZN_W'({n_r, 1'b0});
    cfg_nxt.nbelt = cfg_nxt.npix - PIX_W'(cfg_nxt.ncap);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= N_W'(1);
      nsq_r <= KSQ_W'(1);
    end else if (cfg_we) begin
      n_r   <= n_eff;
      nsq_r <= nsq_full[KSQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    cfg_r <= cfg_nxt;
  end

  // pipeline holds only when the last stage is full and the output is blocked
  assign en          = !(last_v && out_v_r && !out_ch.ready);
  assign in_ch.ready = en;

  hrpa_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (in_ch.valid),
    .in_pix (in_ch.pixel_index),
    .cfg    (cfg_r),
    .out_v  (fr_v),
    .out_d  (fr_d)
  );

  hrpa_root_div u_root_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (fr_v),
    .in_d  (fr_d),
    .cfg   (cfg_r),
    .out_v (rd_v),
    .out_d (rd_d)
  );

  hrpa_ring_map u_ring_map (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (rd_v),
    .in_d  (rd_d),
    .cfg   (cfg_r),
    .out_v (rm_v),
    .out_d (rm_d)
  );

  hrpa_frac_div u_frac_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (rm_v),
    .in_d  (rm_d),
    .out_v (last_v),
    .out_d (last_d)
  );

  // round half up on the extra fraction bit
  assign zmag = Z_W'(last_d.zq[Q_W-1:1]) + Z_W'(last_d.zq[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (last_v && en) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_v && en) begin
      out_inv_r <= last_d.invalid;
      if (last_d.invalid) begin
        out_region_r <= REG_NORTH;
        out_ring_r   <= '0;
        out_iphi_r   <= '0;
        out_z_r      <= '0;
        out_phi_r    <= '0;
      end else begin
        out_region_r <= last_d.region;
        out_ring_r   <= last_d.ring;
        out_iphi_r   <= last_d.iphi;
        out_z_r      <= last_d.zneg ? Z_W'(0) - zmag : zmag;
        out_phi_r    <= last_d.pq;
      end
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.region      = out_region_r;
  assign out_ch.ring_number = out_ring_r;
  assign out_ch.ring_pixel  = out_iphi_r;
  assign out_ch.z_cos_theta = out_z_r;
  assign out_ch.phi_angle   = out_phi_r;
  assign out_ch.invalid     = out_inv_r;

  `HRPA_ASSERT_IMP(a_inv_zero, out_v_r && out_inv_r, out_region_r == REG_NORTH && out_ring_r == '0 && out_z_r == '0 && out_phi_r == '0, "invalid result carries data")
  `HRPA_ASSERT_IMP(a_valid_nonzero, out_v_r && !out_inv_r, out_ring_r != '0 && out_iphi_r != '0, "valid result with zero ring or pixel")
  `HRPA_ASSERT_IMP(a_north_pos, out_v_r && !out_inv_r && out_region_r == REG_NORTH, !out_z_r[Z_W-1], "north cap z negative")
  `HRPA_ASSERT_IMP(a_south_neg, out_v_r && !out_inv_r && out_region_r == REG_SOUTH, out_z_r[Z_W-1], "south cap z not negative")

endmodule

`default_nettype wire

// ===== tb/sv/tb_healpix_ring_pixel_to_angle_top.sv =====
// ----------------------------------------------------------------------------
// tb_healpix_ring_pixel_to_angle_top
// streams ring pixel indices through the pipeline under several nside values
// and idle and stall patterns, checking region, ring, pixel, z, phi and invalid of each result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_healpix_ring_pixel_to_angle_top;
  import hrpa_pkg::*;

  typedef struct packed {
    logic [REGION_W-1:0]   region;
    logic [RING_W-1:0]     ring_number;
    logic [IPHI_W-1:0]     ring_pixel;
    logic signed [Z_W-1:0] z_cos_theta;
    logic [PHI_W-1:0]      phi_angle;
    logic                  invalid;
  } angle_t;

  typedef struct {
    logic [N_W-1:0]   ns;
    logic [PIX_W-1:0] pix;
    bit               typed;
    angle_t           val;
  } dir_row_t;

  localparam logic [127:0] PI_2P60 = 128'h3243F6A8885A308D;
  localparam angle_t BAD_PIX = '{'0, '0, '0, '0, '0, 1'b1};
  localparam int LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 225;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [N_W-1:0] cfg_wdata;

  hrpa_in_if  in_ch ();
  hrpa_out_if out_ch ();

  healpix_ring_pixel_to_angle_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  angle_t angle_q[$];
  logic [N_W-1:0] nside_reg;
  int idle_pct;
  int stall_pct;
  int mismatches;
  int cycles;

  dir_row_t dir_tab[] = '{
    '{21'd1, 44'd0, 1'b0, '0},
    '{21'd1, 44'd1, 1'b0, '0},
    '{21'd1, 44'd4, 1'b0, '0},
    '{21'd1, 44'd7, 1'b0, '0},
    '{21'd1, 44'd11, 1'b0, '0},
    '{21'd1, 44'd12, 1'b1, BAD_PIX},
    '{21'd1, 44'hFFFFFFFFFFF, 1'b1, BAD_PIX},
    '{21'd2, 44'd0, 1'b0, '0},
    '{21'd2, 44'd3, 1'b0, '0},
    '{21'd2, 44'd4, 1'b0, '0},
    '{21'd2, 44'd12, 1'b0, '0},
    '{21'd2, 44'd43, 1'b0, '0},
    '{21'd2, 44'd44, 1'b0, '0},
    '{21'd2, 44'd47, 1'b0, '0},
    '{21'd2, 44'd48, 1'b1, BAD_PIX},
    '{21'h100000, 44'd0, 1'b0, '0},
    '{21'h100000, 44'h200_0000_0000, 1'b0, '0},
    '{21'h100000, 44'hBFF_FFFF_FFFF, 1'b0, '0},
    '{21'h100000, 44'hC00_0000_0000, 1'b1, BAD_PIX},
    '{21'd0, 44'd5, 1'b0, '0},
    '{21'd0, 44'd12, 1'b1, BAD_PIX},
    '{21'h1FFFFF, 44'd0, 1'b0, '0},
    '{21'h1FFFFF, 44'h555_5555_5555, 1'b0, '0}
  };

  function automatic longint unsigned eff_nside(logic [N_W-1:0] ns);
    if (ns == 0) return 1;
    if (ns > N_MAX) return N_MAX;
    return ns;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic angle_t predict_angle(logic [N_W-1:0] ns, logic [PIX_W-1:0] pix_in);
    longint unsigned n, p, npix, ncap, k, ip, ring, iphi, m, d, znum, zden, diff;
    logic [127:0] zq, pq;
    logic [63:0] zmag;
    bit zneg;
    angle_t a;
    n = eff_nside(ns);
    p = pix_in;
    npix = 12 * n * n;
    ncap = 2 * n * (n - 1);
    zneg = 0;
    if (p >= npix) return BAD_PIX;
    if (p < ncap) begin
      k = (1 + floor_sqrt(1 + 2 * p)) >> 1;
      a.region = REG_NORTH;
      ring = k;
      iphi = p + 1 - 2 * k * (k - 1);
      znum = 3 * n * n - k * k;
      zden = 3 * n * n;
      m = 2 * iphi - 1;
      d = k;
    end else if (p < npix - ncap) begin
      ip = p - ncap;
      a.region = REG_BELT;
      ring = ip / (4 * n) + n;
      iphi = ip % (4 * n) + 1;
      m = ((ring + n) & 1) ? 2 * iphi - 2 : 2 * iphi - 1;
      d = n;
      if (ring > 2 * n) begin
        diff = ring - 2 * n;
        zneg = 1;
      end else begin
        diff = 2 * n - ring;
      end
      znum = 2 * diff;
      zden = 3 * n;
    end else begin
      ip = npix - p;
      k = (1 + floor_sqrt(2 * ip - 1)) >> 1;
      a.region = REG_SOUTH;
      ring = 4 * n - k;
      iphi = 4 * k + 1 - (ip - 2 * k * (k - 1));
      znum = 3 * n * n - k * k;
      zden = 3 * n * n;
      zneg = 1;
      m = 2 * iphi - 1;
      d = k;
    end
    zq = ({64'd0, znum} << 31) / {64'd0, zden};
    zmag = 64'((zq + 1) >> 1);
    a.ring_number = ring[RING_W-1:0];
    a.ring_pixel = iphi[IPHI_W-1:0];
    a.z_cos_theta = zneg ? -zmag[Z_W-1:0] : zmag[Z_W-1:0];
    pq = (PI_2P60 * {64'd0, m} * 2) / {64'd0, 4 * d};
    pq = (pq + (128'd1 << 30)) >> 31;
    a.phi_angle = pq[PHI_W-1:0];
    a.invalid = 1'b0;
    return a;
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel(logic [N_W-1:0] ns);
    longint unsigned n, npix, ncap, r;
    n = eff_nside(ns);
    npix = 12 * n * n;
    ncap = 2 * n * (n - 1);
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      7: begin
        case ($urandom_range(3))
          0: r = ncap + $urandom_range(2) - 1;
          1: r = npix - ncap + $urandom_range(2) - 1;
          2: r = npix - 1 - $urandom_range(3);
          default: r = $urandom_range(3);
        endcase
        if (r >= npix) r = npix - 1;
      end
      8: r = npix + $urandom_range(3);
      9: r = r;
      default: r = r % npix;
    endcase
    return r[PIX_W-1:0];
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.pixel_index = '0;
    out_ch.ready = 1'b0;
  end

  // receiver side
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    angle_t got, want;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_healpix_ring_pixel_to_angle_top NOT OK");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.region, out_ch.ring_number, out_ch.ring_pixel,
              out_ch.z_cos_theta, out_ch.phi_angle, out_ch.invalid};
      if (angle_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %p", got);
      end else begin
        want = angle_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  task automatic drain();
    while (angle_q.size() != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  task automatic write_nside(logic [N_W-1:0] v);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    nside_reg = v;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] p, bit typed, angle_t val);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.pixel_index = p;
    do @(posedge clk); while (!in_ch.ready);
    angle_q.push_back(typed ? val : predict_angle(nside_reg, p));
    @(negedge clk);
  endtask

  initial begin
    logic [N_W-1:0] phase_ns [8];
    mismatches = 0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    nside_reg = 21'd1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].ns != nside_reg) begin
        in_ch.valid = 1'b0;
        write_nside(dir_tab[i].ns);
      end
      send_pixel(dir_tab[i].pix, dir_tab[i].typed, dir_tab[i].val);
    end

    phase_ns = '{21'd3, 21'h100000, 21'($urandom_range(4096, 1)), 21'd7,
                 21'h1FFFFF, 21'($urandom), 21'd0, 21'($urandom_range(1 << 20, 1))};
    for (int ph = 0; ph < 8; ph++) begin
      in_ch.valid = 1'b0;
      write_nside(phase_ns[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // hold off until the pipeline has emptied
        if (ph == 2 && i == ITEMS_PER_PHASE / 2) begin
          in_ch.valid = 1'b0;
          while (angle_q.size() != 0) @(negedge clk);
        end
        send_pixel(random_pixel(nside_reg), 1'b0, '0);
      end
    end
    in_ch.valid = 1'b0;
    stall_pct = 0;
    while (angle_q.size() != 0) @(negedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_healpix_ring_pixel_to_angle_top OK");
    end else begin
      $display("tb_healpix_ring_pixel_to_angle_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/hrpa_pkg.sv
hdl/hrpa_if.sv
hdl/hrpa_front.sv
hdl/hrpa_root_div.sv
hdl/hrpa_ring_map.sv
hdl/hrpa_frac_div.sv
hdl/healpix_ring_pixel_to_angle_top.sv
tb/sv/tb_healpix_ring_pixel_to_angle_top.sv
